[hdl/gate_occupancy_direction_counter_defines.svh]
// Assertion macros shared by the gate occupancy counter RTL.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef GATE_OCCUPANCY_DIRECTION_COUNTER_DEFINES_SVH
`define GATE_OCCUPANCY_DIRECTION_COUNTER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Checked outside reset only.
`define GODC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define GODC_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) (expr)) else $error(msg);

`else

`define GODC_ASSERT(lbl, prop, msg)
`define GODC_ASSERT_ALWAYS(lbl, expr, msg)

`endif

`endif

[hdl/godc_pkg.sv]
// Shared types, constants and gate geometry for the gate occupancy counter.
// No dependencies.
`timescale 1ns / 1ps

package godc_pkg;

    localparam int GATE_COUNT_DEF = 4;
    localparam int COORD_BITS_DEF = 10;
    localparam int MAX_GATES      = 8;

    // Row spans and coordinates are compared at this width (above any coordinate).
    localparam int SPAN_BITS   = 13;
    localparam int EDGE_BITS   = 10;
    localparam int COUNT_BITS  = 13;
    localparam int TOTAL_BITS  = 16;
    localparam int PIX_BITS    = 8;
    localparam int OCC_BITS    = 4;
    localparam int ACT_BITS    = 4;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 13;

    localparam logic [PIX_BITS-1:0]   PIX_WHITE = 8'hFF;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = 13'h1FFF;

    localparam logic [EDGE_BITS-1:0]  LEFT_RESET    = 10'd238;
    localparam logic [EDGE_BITS-1:0]  RIGHT_RESET   = 10'd401;
    localparam logic [COUNT_BITS-1:0] TRIGGER_RESET = 13'd125;
    localparam logic [COUNT_BITS-1:0] RELEASE_RESET = 13'd10;

    // Half-open row span of each gate; gates past the fourth never match.
    localparam logic [SPAN_BITS-1:0] ROW_TOP [MAX_GATES] =
        '{13'd0, 13'd40, 13'd145, 13'd230, 13'd0, 13'd0, 13'd0, 13'd0};
    localparam logic [SPAN_BITS-1:0] ROW_BOTTOM [MAX_GATES] =
        '{13'd10, 13'd60, 13'd185, 13'd270, 13'd0, 13'd0, 13'd0, 13'd0};

    // Pixel queue between classifier and counters; depth is a power of two.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_GATE_LEFT  = 2'd0,
        CFG_GATE_RIGHT = 2'd1,
        CFG_TRIGGER    = 2'd2,
        CFG_RELEASE    = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [EDGE_BITS-1:0] left;
        logic [EDGE_BITS-1:0] right;
    } godc_span_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0] trigger;
        logic [COUNT_BITS-1:0] release_lvl;
    } godc_levels_t;

endpackage

[hdl/godc_front.sv]
// Front end: accepts pixels and turns each into a gate hit mask plus frame flag.
// Depends on godc_pkg.
`timescale 1ns / 1ps

module godc_front import godc_pkg::*;
#(
    parameter int GATE_COUNT = GATE_COUNT_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [COORD_BITS-1:0] column,
    input  logic [COORD_BITS-1:0] row,
    input  logic [PIX_BITS-1:0]   pixel_value,
    input  logic                  frame_end,
    input  godc_span_t            span,
    input  logic                  q_full,
    output logic                  push,
    output logic [GATE_COUNT-1:0] hits,
    output logic                  last
);

    localparam logic [SPAN_BITS-1:0] COORD_MASK = SPAN_BITS'((1 << COORD_BITS) - 1);

    logic [SPAN_BITS-1:0] col_x;
    logic [SPAN_BITS-1:0] row_x;
    logic [SPAN_BITS-1:0] left_x;
    logic [SPAN_BITS-1:0] right_x;
    logic                 in_cols;

    assign in_ready = !q_full;
    assign push     = in_valid && !q_full;
    assign last     = frame_end;

    assign col_x   = SPAN_BITS'(column);
    assign row_x   = SPAN_BITS'(row);
    // Column edges wrap to the coordinate width.
    assign left_x  = SPAN_BITS'(span.left) & COORD_MASK;
    assign right_x = SPAN_BITS'(span.right) & COORD_MASK;
    assign in_cols = (pixel_value == PIX_WHITE) && (col_x >= left_x) && (col_x < right_x);

    for (genvar g = 0; g < GATE_COUNT; g++) begin : g_hit
        assign hits[g] = in_cols && (row_x >= ROW_TOP[g]) && (row_x < ROW_BOTTOM[g]);
    end

endmodule

[hdl/godc_queue.sv]
// Short FIFO of classified pixels between the front end and the counters.
// Depends on godc_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "gate_occupancy_direction_counter_defines.svh"

module godc_queue import godc_pkg::*;
#(
    parameter int WIDTH = GATE_COUNT_DEF + 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic             rvalid,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0]     mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wptr_reg;
    logic [QPTR_BITS-1:0] wptr_next;
    logic [QPTR_BITS-1:0] rptr_reg;
    logic [QPTR_BITS-1:0] rptr_next;
    logic [QCNT_BITS-1:0] count_reg;
    logic [QCNT_BITS-1:0] count_next;

    assign full   = (count_reg == QCNT_BITS'(QUEUE_DEPTH));
    assign rvalid = (count_reg != '0);
    assign rdata  = mem[rptr_reg];

    always_comb
    begin
        wptr_next  = push ? wptr_reg + QPTR_BITS'(1) : wptr_reg;
        rptr_next  = pop ? rptr_reg + QPTR_BITS'(1) : rptr_reg;
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_BITS'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wptr_reg] <= wdata;
        end
    end

    `GODC_ASSERT_ALWAYS(a_q_bound, count_reg <= QCNT_BITS'(QUEUE_DEPTH), "queue fill out of range")
    `GODC_ASSERT(a_q_grow, push && !pop |=> count_reg == $past(count_reg) + QCNT_BITS'(1), "queue fill did not grow")

endmodule

[hdl/godc_back.sv]
// Back end: per-gate pixel counters, frame-end hysteresis, direction totals
// and the result register. Depends on godc_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "gate_occupancy_direction_counter_defines.svh"

module godc_back import godc_pkg::*;
#(
    parameter int GATE_COUNT = GATE_COUNT_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    input  logic [GATE_COUNT-1:0] q_hits,
    input  logic                  q_last,
    output logic                  q_pop,
    input  godc_levels_t          levels,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [TOTAL_BITS-1:0] westbound_total,
    output logic [TOTAL_BITS-1:0] eastbound_total,
    output logic                  westbound_changed,
    output logic [OCC_BITS-1:0]   gates_occupied
);

    logic [COUNT_BITS-1:0] count_reg [GATE_COUNT];
    logic [COUNT_BITS-1:0] count_inc [GATE_COUNT];
    logic [GATE_COUNT-1:0] occ_reg;
    logic [GATE_COUNT-1:0] occ_next;
    logic [GATE_COUNT-1:0] act;
    logic [ACT_BITS-1:0]   west_adds;
    logic [ACT_BITS-1:0]   east_adds;
    logic [TOTAL_BITS-1:0] west_total_reg;
    logic [TOTAL_BITS-1:0] west_total_next;
    logic [TOTAL_BITS-1:0] east_total_reg;
    logic [TOTAL_BITS-1:0] east_total_next;
    logic [OCC_BITS-1:0]   occ_bits;
    logic                  out_valid_reg;
    logic                  west_changed_reg;
    logic [OCC_BITS-1:0]   occ_out_reg;
    logic                  frame_pop;
    logic                  any_count;

    // A frame-end entry needs room in the result register; plain pixels never wait.
    assign q_pop     = q_valid && (!q_last || !out_valid_reg || out_ready);
    assign frame_pop = q_pop && q_last;

    always_comb
    begin
        west_adds = '0;
        east_adds = '0;
        any_count = 1'b0;
        for (int g = 0; g < GATE_COUNT; g++)
        begin
            count_inc[g] = (q_hits[g] && (count_reg[g] != COUNT_MAX))
                         ? count_reg[g] + COUNT_BITS'(1) : count_reg[g];
            act[g]      = 1'b0;
            occ_next[g] = occ_reg[g];
            // Trigger wins a tie for a free gate; release wins for an occupied one.
            if ((count_inc[g] >= levels.trigger) && !occ_reg[g])
            begin
                occ_next[g] = 1'b1;
                act[g]      = 1'b1;
            end
            else if (count_inc[g] <= levels.release_lvl)
            begin
                occ_next[g] = 1'b0;
            end
            if (g < GATE_COUNT / 2)
            begin
                west_adds = west_adds + ACT_BITS'(act[g]);
            end
            else
            begin
                east_adds = east_adds + ACT_BITS'(act[g]);
            end
            any_count = any_count || (count_reg[g] != '0);
        end
        west_total_next = west_total_reg + TOTAL_BITS'(west_adds);
        east_total_next = east_total_reg + TOTAL_BITS'(east_adds);
    end

    for (genvar i = 0; i < OCC_BITS; i++) begin : g_occ
        if (i < GATE_COUNT) begin : g_used
            assign occ_bits[i] = occ_next[i];
        end
        else begin : g_unused
            assign occ_bits[i] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int g = 0; g < GATE_COUNT; g++)
            begin
                count_reg[g] <= '0;
            end
            occ_reg        <= '0;
            west_total_reg <= '0;
            east_total_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                for (int g = 0; g < GATE_COUNT; g++)
                begin
                    count_reg[g] <= q_last ? '0 : count_inc[g];
                end
            end
            if (frame_pop)
            begin
                occ_reg        <= occ_next;
                west_total_reg <= west_total_next;
                east_total_reg <= east_total_next;
                out_valid_reg  <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_pop)
        begin
            west_changed_reg <= (west_adds != '0);
            occ_out_reg      <= occ_bits;
        end
    end

    assign out_valid         = out_valid_reg;
    assign westbound_total   = west_total_reg;
    assign eastbound_total   = east_total_reg;
    assign westbound_changed = west_changed_reg;
    assign gates_occupied    = occ_out_reg;

    `GODC_ASSERT(a_counts_cleared, frame_pop |=> !any_count, "gate counts not cleared at frame end")
    `GODC_ASSERT(a_west_hold, !frame_pop |=> $stable(west_total_reg), "westbound total moved mid frame")
    `GODC_ASSERT(a_west_flag, frame_pop |=> westbound_changed == (west_total_reg != $past(west_total_reg)), "westbound flag disagrees with total")

endmodule

[hdl/gate_occupancy_direction_counter.sv]
// Top level of the gate occupancy direction counter: config registers and the
// front / queue / back split. Depends on godc_pkg, godc_front, godc_queue, godc_back.
`timescale 1ns / 1ps

// Channel  Handshake              Payload
// in       in_valid / in_ready    column, row, pixel_value, frame_end
// out      out_valid / out_ready  westbound_total, eastbound_total,
//                                 westbound_changed, gates_occupied
// cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One pixel item per clock while in_ready is high. A pixel is classified in
// its accept cycle and written to a two-entry queue; the counter stage takes
// one entry per cycle, and only a frame-end entry waits on a full result
// register; the queue absorbs that stall and in_ready drops once it is full.
// Reset sets config to defaults, clears counts, occupancy and totals (not
// westbound_changed, gates_occupied); no clear pass. cfg_ready is always high.

module gate_occupancy_direction_counter import godc_pkg::*;
#(
    parameter int GATE_COUNT = GATE_COUNT_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [COORD_BITS-1:0]    column,
    input  logic [COORD_BITS-1:0]    row,
    input  logic [PIX_BITS-1:0]      pixel_value,
    input  logic                     frame_end,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [TOTAL_BITS-1:0]    westbound_total,
    output logic [TOTAL_BITS-1:0]    eastbound_total,
    output logic                     westbound_changed,
    output logic [OCC_BITS-1:0]      gates_occupied,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    localparam int ENTRY_BITS = GATE_COUNT + 1;

    godc_span_t            span_reg;
    godc_span_t            span_next;
    godc_levels_t          levels_reg;
    godc_levels_t          levels_next;

    logic                  q_full;
    logic                  push;
    logic [GATE_COUNT-1:0] hits;
    logic                  last;
    logic [ENTRY_BITS-1:0] q_rdata;
    logic                  q_valid;
    logic                  q_pop;

    assign cfg_ready = 1'b1;

    // Register writes; column edges keep 10 bits, levels keep 13.
    always_comb
    begin
        span_next   = span_reg;
        levels_next = levels_reg;
        if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_GATE_LEFT:  span_next.left          = cfg_data[EDGE_BITS-1:0];
                CFG_GATE_RIGHT: span_next.right         = cfg_data[EDGE_BITS-1:0];
                CFG_TRIGGER:    levels_next.trigger     = cfg_data[COUNT_BITS-1:0];
                CFG_RELEASE:    levels_next.release_lvl = cfg_data[COUNT_BITS-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            span_reg.left          <= LEFT_RESET;
            span_reg.right         <= RIGHT_RESET;
            levels_reg.trigger     <= TRIGGER_RESET;
            levels_reg.release_lvl <= RELEASE_RESET;
        end
        else
        begin
            span_reg   <= span_next;
            levels_reg <= levels_next;
        end
    end

    // Classifier: white pixel inside the shared column span and a gate's rows.
    godc_front #(
        .GATE_COUNT (GATE_COUNT),
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .column      (column),
        .row         (row),
        .pixel_value (pixel_value),
        .frame_end   (frame_end),
        .span        (span_reg),
        .q_full      (q_full),
        .push        (push),
        .hits        (hits),
        .last        (last)
    );

    // Entry layout: frame flag on top, one hit bit per gate below.
    godc_queue #(
        .WIDTH (ENTRY_BITS)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wdata  ({last, hits}),
        .full   (q_full),
        .pop    (q_pop),
        .rvalid (q_valid),
        .rdata  (q_rdata)
    );

    // Counters, hysteresis at frame end, direction totals, result register.
    godc_back #(
        .GATE_COUNT (GATE_COUNT)
    ) u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .q_valid           (q_valid),
        .q_hits            (q_rdata[GATE_COUNT-1:0]),
        .q_last            (q_rdata[GATE_COUNT]),
        .q_pop             (q_pop),
        .levels            (levels_reg),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .westbound_total   (westbound_total),
        .eastbound_total   (eastbound_total),
        .westbound_changed (westbound_changed),
        .gates_occupied    (gates_occupied)
    );

endmodule
